FILE: rtl/bba_pkg.sv
// Package for the bitmap block allocator.
// Holds field widths, function codes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package bba_pkg;

  localparam int WORD_W      = 32;   // map bits held in one memory word
  localparam int BIT_W       = 5;    // bit position inside a map word
  localparam int BS_W        = 16;
  localparam int SIZE_W      = 24;
  localparam int START_W     = 10;
  localparam int IDX_W       = 10;
  localparam int FREED_W     = 11;
  localparam int CNT_W       = SIZE_W + 1;
  localparam int ENDC_W      = CNT_W + 1;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - FREED_W;
  localparam int FREED_MAX   = 2047;

  localparam logic [BS_W-1:0] BS_RESET = 16'd64;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_DIV,
    ST_F_CNT,
    ST_F_RNG,
    ST_F_RD,
    ST_F_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_start;
    logic a_step;
    logic f_cnt;
    logic f_rng;
    logic f_wr;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic a_hit;
    logic a_last;
    logic div_done;
    logic f_none;
    logic f_last;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/bba_div.sv
// Iterative restoring divider for the bitmap block allocator, one quotient
// bit per cycle. Depends on bba_pkg for the operand widths.
module bba_div import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [BS_W-1:0]   divisor,
  output logic              done,
  output logic [SIZE_W-1:0] quot,
  output logic              rem_nz
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [BIT_W-1:0]  step_r, step_nxt;
  logic [BS_W:0]     rem_r, rem_nxt;
  logic [SIZE_W-1:0] quo_r, quo_nxt;
  logic [BS_W-1:0]   dsr_r, dsr_nxt;
  logic [BS_W:0]     shifted;
  logic [BS_W:0]     diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r[BS_W-1:0], quo_r[SIZE_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff : shifted;
      quo_nxt  = {quo_r[SIZE_W-2:0], ge};
      step_nxt = step_r + BIT_W'(1);
      if (step_r == BIT_W'(SIZE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_nz = |rem_r;

endmodule

FILE: rtl/bba_datapath.sv
// Datapath of the bitmap block allocator: occupancy map memory, word scan,
// run clearing, block size register, divider and result register.
// Depends on bba_pkg and bba_div.
module bba_datapath import bba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   cfg_valid,
  input  logic [BS_W-1:0]        cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int EW        = $clog2(NUM_BLOCKS + 1);
  localparam int PAD_BITS  = NUM_BLOCKS % WORD_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);
  // Bits of the last word that lie past the map end read as used.
  localparam logic [WORD_W-1:0] PAD =
    (PAD_BITS == 0) ? '0 : ({WORD_W{1'b1}} << PAD_BITS);

  logic [WORD_W-1:0] map_mem [NUM_WORDS];
  logic [WORD_W-1:0] rdata_r;

  logic [AW-1:0]      waddr_r, waddr_nxt;
  logic [BS_W-1:0]    bs_r;
  logic [START_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ENDC_W-1:0]  endc_r, endc_nxt;
  logic [EW-1:0]      room_r, room_nxt;
  logic [EW-1:0]      end_r, end_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [FREED_W-1:0] freed_r, freed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  logic [BS_W-1:0]    bs_eff;
  logic               div_done;
  logic [SIZE_W-1:0]  quot;
  logic               rem_nz;

  logic [WORD_W-1:0]  word_v;
  logic [BIT_W-1:0]   pos;
  logic               a_hit;
  logic [31:0]        gidx;
  logic [WORD_W-1:0]  clr_mask;
  logic [31:0]        base;
  logic               f_none;
  logic               f_last;
  logic               sat_end;
  logic [31:0]        run;
  logic               mem_we;
  logic [WORD_W-1:0]  mem_wdata;

  assign bs_eff = (bs_r == '0) ? BS_W'(1) : bs_r;

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (in_tdata[START_W +: SIZE_W]),
    .divisor  (bs_eff),
    .done     (div_done),
    .quot     (quot),
    .rem_nz   (rem_nz)
  );

  // Allocate: lowest zero bit of the word just read.
  always_comb begin
    word_v = rdata_r | ((waddr_r == LAST_ADDR) ? PAD : '0);
    a_hit  = ~&word_v;
    pos    = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word_v[b]) pos = BIT_W'(b);
    end
    gidx = 32'({waddr_r, pos});
  end

  // Free: bits of this word that fall inside [start, end).
  always_comb begin
    base = 32'({waddr_r, {BIT_W{1'b0}}});
    for (int b = 0; b < WORD_W; b++) begin
      clr_mask[b] = ((base + 32'(b)) >= 32'(start_r)) && ((base + 32'(b)) < 32'(end_r));
    end
    f_last  = (base + 32'(WORD_W)) >= 32'(end_r);
    f_none  = (32'(start_r) >= 32'(NUM_BLOCKS)) || (cnt_r == '0);
    sat_end = 32'(endc_r) >= 32'(NUM_BLOCKS);
    run     = sat_end ? 32'(room_r) : 32'(cnt_r);
  end

  always_comb begin
    mem_we    = cmd.clr_step | (cmd.a_step & a_hit) | cmd.f_wr;
    mem_wdata = rdata_r & ~clr_mask;
    if (cmd.clr_step) begin
      mem_wdata = '0;
    end else if (cmd.a_step) begin
      mem_wdata = rdata_r | (WORD_W'(1) << pos);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[waddr_r] <= mem_wdata;
    end
    rdata_r <= map_mem[waddr_r];
  end

  always_comb begin
    waddr_nxt = waddr_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    endc_nxt  = endc_r;
    room_nxt  = room_r;
    end_nxt   = end_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    freed_nxt = freed_r;
    if (cmd.clr_step) begin
      waddr_nxt = (waddr_r == LAST_ADDR) ? '0 : waddr_r + AW'(1);
    end
    if (cmd.load) begin
      waddr_nxt = '0;
      start_nxt = in_tdata[START_W-1:0];
      idx_nxt   = '0;
      found_nxt = (in_tuser == FUNC_FREE);
      freed_nxt = '0;
    end
    if (cmd.a_step) begin
      if (a_hit) begin
        idx_nxt   = gidx[IDX_W-1:0];
        found_nxt = 1'b1;
      end else if (waddr_r != LAST_ADDR) begin
        waddr_nxt = waddr_r + AW'(1);
      end
    end
    if (cmd.f_cnt) begin
      cnt_nxt  = CNT_W'(quot) + CNT_W'(rem_nz);
      endc_nxt = ENDC_W'(start_r) + ENDC_W'(quot) + ENDC_W'(rem_nz);
      room_nxt = EW'(NUM_BLOCKS) - EW'(start_r);
    end
    if (cmd.f_rng) begin
      waddr_nxt = AW'(start_r >> BIT_W);
      end_nxt   = sat_end ? EW'(NUM_BLOCKS) : EW'(endc_r);
      if (f_none) begin
        freed_nxt = '0;
      end else if (run > 32'(FREED_MAX)) begin
        freed_nxt = FREED_W'(FREED_MAX);
      end else begin
        freed_nxt = run[FREED_W-1:0];
      end
    end
    if (cmd.f_wr && !f_last) begin
      waddr_nxt = waddr_r + AW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (cmd.resp_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{OUT_PAD_W{1'b0}}, freed_r, idx_r};
      out_user_nxt  = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waddr_r     <= '0;
      bs_r        <= BS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      waddr_r     <= waddr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        bs_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r    <= start_nxt;
    cnt_r      <= cnt_nxt;
    endc_r     <= endc_nxt;
    room_r     <= room_nxt;
    end_r      <= end_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    freed_r    <= freed_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    sts.clr_last = (waddr_r == LAST_ADDR);
    sts.a_hit    = a_hit;
    sts.a_last   = (waddr_r == LAST_ADDR);
    sts.div_done = div_done;
    sts.f_none   = f_none;
    sts.f_last   = f_last;
    sts.out_busy = out_valid_r & ~out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
// Sequences the clearing pass, the scan and the free; depends on bba_pkg.
module bba_ctrl import bba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser == FUNC_FREE) ? ST_DIV : ST_A_RD;
        end
      end
      ST_A_RD:  state_nxt = ST_A_CHK;
      ST_A_CHK: state_nxt = (sts.a_hit || sts.a_last) ? ST_RESP : ST_A_RD;
      ST_DIV:   if (sts.div_done) state_nxt = ST_F_CNT;
      ST_F_CNT: state_nxt = ST_F_RNG;
      ST_F_RNG: state_nxt = sts.f_none ? ST_RESP : ST_F_RD;
      ST_F_RD:  state_nxt = ST_F_WR;
      ST_F_WR:  state_nxt = sts.f_last ? ST_RESP : ST_F_RD;
      ST_RESP:  if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.load      = in_tvalid;
        cmd.div_start = in_tvalid && (in_tuser == FUNC_FREE);
      end
      ST_A_CHK: cmd.a_step = 1'b1;
      ST_F_CNT: cmd.f_cnt = 1'b1;
      ST_F_RNG: cmd.f_rng = 1'b1;
      ST_F_WR:  cmd.f_wr = 1'b1;
      ST_RESP:  cmd.resp_load = ~sts.out_busy;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/bitmap_block_allocator.sv
// First-fit block allocator over a one-bit-per-block occupancy map held in a
// memory of 32-bit words. An allocate finds, marks and returns the lowest
// free block; a free clears ceil(size / bytes per block) blocks from start_block,
// clipped at the map end. One item is worked at a time. After reset a
// clearing pass writes ceil(NUM_BLOCKS/32) words, one per cycle, before the
// first item is taken. An allocate scans the map word by word, reading each
// word and checking it, up to the first word with a free bit. A free runs
// the 24-step bit-serial divider, sets up the range, then reads and writes
// each map word touched by the run through the single map port. Results
// wait in an output register until transferred.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // start_block, file_size_bytes, zero pad
  input  logic                   in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // block_index, freed_count, zero pad
  output logic                   out_tuser,  // found
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [BS_W-1:0]        cfg_data    // bytes per block
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/bba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg for the field widths.
module bba_checker import bba_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A result waiting for its transfer holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // After reset the map is being cleared and no result is pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  // Only one item is taken at a time.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // A failed allocate reports index zero and clears nothing; a free that
  // cleared blocks reports index zero and success.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser || (out_tdata[IDX_W+FREED_W-1:0] == '0)) &&
                   ((out_tdata[IDX_W +: FREED_W] == '0) ||
                    (out_tuser && (out_tdata[IDX_W-1:0] == '0))))
    else $error("inconsistent result fields");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: sim/tb_top.sv
// Self-checking bench for bitmap_block_allocator: directed table and random phases
// over several block sizes, scored against an in-bench occupancy model.
// Depends on rtl/bba_pkg.sv and rtl/bitmap_block_allocator.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int NBLK        = 1024;
  localparam int IN_PAD      = IN_TDATA_W - START_W - SIZE_W;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               found;
    logic [FREED_W-1:0] freed;
  } reply_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // amount is the byte count of a request, or the new block size on a config row.
  typedef struct packed {
    row_kind_t           kind;
    logic                fn;
    logic [START_W-1:0]  start;
    logic [SIZE_W-1:0]   amount;
    logic                typed;
    logic [IDX_W-1:0]    e_idx;
    logic                e_found;
    logic [FREED_W-1:0]  e_freed;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // start_block, file_size_bytes, zero pad
  logic                   in_tuser = 1'b0; // func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // block_index, freed_count, zero pad
  logic                   out_tuser;       // found
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [BS_W-1:0]        cfg_data = '0;   // bytes per block

  bitmap_block_allocator #(.NUM_BLOCKS(NBLK)) dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Occupancy model and the replies still owed by the block.
  logic [NBLK-1:0] used_map = '0;
  logic [BS_W-1:0] blk_size_q = BS_RESET;
  reply_t          pending_replies[$];
  int              mismatches = 0;
  bit              calm = 1'b0;
  int              hold_req = 0;
  int              hold_seen = 0;
  int              sink_gap = 0;
  int              idle_cycles = 0;
  logic [BS_W-1:0] phase_bs [6] = '{16'd1, 16'd65535, 16'd300, 16'd512, 16'd4096, 16'd64};

  stim_row_t plan [20] = '{
    '{ROW_ITEM, FUNC_ALLOC, 10'd0,    24'd0,       1'b1, 10'd0, 1'b1, 11'd0},
    '{ROW_ITEM, FUNC_ALLOC, 10'd0,    24'd0,       1'b1, 10'd1, 1'b1, 11'd0},
    '{ROW_ITEM, FUNC_ALLOC, 10'd0,    24'd0,       1'b1, 10'd2, 1'b1, 11'd0},
    // An empty run still completes.
    '{ROW_ITEM, FUNC_FREE,  10'd1,    24'd0,       1'b1, 10'd0, 1'b1, 11'd0},
    '{ROW_ITEM, FUNC_FREE,  10'd1,    24'd1,       1'b1, 10'd0, 1'b1, 11'd1},
    '{ROW_ITEM, FUNC_ALLOC, 10'd0,    24'd0,       1'b1, 10'd1, 1'b1, 11'd0},
    // Runs clipped at the map end, and free blocks counted anyway.
    '{ROW_ITEM, FUNC_FREE,  10'd1023, 24'hFFFFFF,  1'b1, 10'd0, 1'b1, 11'd1},
    '{ROW_ITEM, FUNC_FREE,  10'd0,    24'hFFFFFF,  1'b1, 10'd0, 1'b1, 11'd1024},
    '{ROW_ITEM, FUNC_ALLOC, 10'd1023, 24'hFFFFFF,  1'b1, 10'd0, 1'b1, 11'd0},
    '{ROW_ITEM, FUNC_FREE,  10'd0,    24'd64,      1'b1, 10'd0, 1'b1, 11'd1},
    '{ROW_ITEM, FUNC_FREE,  10'd0,    24'd65,      1'b1, 10'd0, 1'b1, 11'd2},
    '{ROW_ITEM, FUNC_FREE,  10'd1000, 24'd6400,    1'b1, 10'd0, 1'b1, 11'd24},
    // A block size of zero acts as one byte per block.
    '{ROW_CFG,  FUNC_ALLOC, 10'd0,    24'd0,       1'b0, 10'd0, 1'b0, 11'd0},
    '{ROW_ITEM, FUNC_FREE,  10'd5,    24'd3,       1'b1, 10'd0, 1'b1, 11'd3},
    '{ROW_ITEM, FUNC_ALLOC, 10'd0,    24'd0,       1'b1, 10'd0, 1'b1, 11'd0},
    '{ROW_ITEM, FUNC_FREE,  10'd0,    24'hFFFFFF,  1'b1, 10'd0, 1'b1, 11'd1024},
    '{ROW_CFG,  FUNC_ALLOC, 10'd0,    24'd65535,   1'b0, 10'd0, 1'b0, 11'd0},
    '{ROW_ITEM, FUNC_FREE,  10'd10,   24'hFFFFFF,  1'b1, 10'd0, 1'b1, 11'd257},
    '{ROW_ITEM, FUNC_FREE,  10'd0,    24'd65536,   1'b1, 10'd0, 1'b1, 11'd2},
    '{ROW_ITEM, FUNC_ALLOC, 10'd0,    24'd0,       1'b0, 10'd0, 1'b0, 11'd0}
  };

  function automatic reply_t allocator_outcome(input logic fn, input logic [START_W-1:0] st,
                                               input logic [SIZE_W-1:0] sz);
    reply_t          r;
    bit              hit;
    longint unsigned bs, nrun, room;
    r   = '0;
    hit = 1'b0;
    if (fn == FUNC_ALLOC) begin
      for (int i = 0; i < NBLK; i++) begin
        if (!hit && !used_map[i]) begin
          used_map[i] = 1'b1;
          r.idx       = i[IDX_W-1:0];
          r.found     = 1'b1;
          hit         = 1'b1;
        end
      end
    end else begin
      bs      = (blk_size_q == '0) ? 1 : blk_size_q;
      nrun    = (longint'(sz) + bs - 1) / bs;
      r.found = 1'b1;
      if (st < NBLK) begin
        room = NBLK - st;
        if (nrun > room) nrun = room;
        for (longint unsigned i = 0; i < nrun; i++) used_map[st + i] = 1'b0;
        r.freed = (nrun > FREED_MAX) ? FREED_MAX[FREED_W-1:0] : nrun[FREED_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic offer_item(input logic fn, input logic [START_W-1:0] st,
                            input logic [SIZE_W-1:0] sz, input bit typed, input reply_t given);
    reply_t want;
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {{IN_PAD{1'b0}}, sz, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = allocator_outcome(fn, st, sz);
    pending_replies.push_back(typed ? given : want);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_replies_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // The block is idle once every reply is in, so the register may change then.
  task automatic set_blk_bytes(input logic [BS_W-1:0] value);
    wait_replies_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    blk_size_q = value;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      sink_gap   <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap   <= sink_gap - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap   <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected transfer: block_index %0d found %0b freed_count %0d",
               out_tdata[IDX_W-1:0], out_tuser, out_tdata[IDX_W +: FREED_W]);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[IDX_W-1:0] !== want.idx) begin
          $error("block_index: expected %0d, got %0d", want.idx, out_tdata[IDX_W-1:0]);
          mismatches++;
        end
        if (out_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tuser);
          mismatches++;
        end
        if (out_tdata[IDX_W +: FREED_W] !== want.freed) begin
          $error("freed_count: expected %0d, got %0d", want.freed,
                 out_tdata[IDX_W +: FREED_W]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    reply_t            given;
    logic              fn;
    logic [START_W-1:0] st;
    logic [SIZE_W-1:0] sz;
    int unsigned       pick, nrun;
    longint unsigned   span, eff_bs;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(plan); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        set_blk_bytes(plan[i].amount[BS_W-1:0]);
      end else begin
        given = '{plan[i].e_idx, plan[i].e_found, plan[i].e_freed};
        offer_item(plan[i].fn, plan[i].start, plan[i].amount, plan[i].typed, given);
        maybe_pause();
      end
    end

    phase_bs[2] = BS_W'($urandom_range(2, 65534));
    for (int ph = 0; ph < 6; ph++) begin
      set_blk_bytes(phase_bs[ph]);
      if (ph == 5) calm <= 1'b1;
      if (ph == 1) hold_req <= hold_req + 1;
      eff_bs = (blk_size_q == '0) ? 1 : blk_size_q;
      for (int k = 0; k < 100; k++) begin
        if (ph == 2 && k == 50) wait_replies_drained();
        pick = $urandom_range(0, 99);
        st   = $urandom_range(0, 1) ? START_W'($urandom_range(0, NBLK - 1)) :
                                      START_W'($urandom_range(0, 127));
        if (pick < 55) begin
          fn = FUNC_ALLOC;
          sz = SIZE_W'($urandom_range(0, 24'hFFFFFF));
        end else if (pick < 90) begin
          fn   = FUNC_FREE;
          nrun = $urandom_range(0, 40);
          span = nrun * eff_bs;
          if (nrun != 0) span = span - $urandom_range(0, 32'(eff_bs - 1));
          sz   = (span > 24'hFFFFFF) ? 24'hFFFFFF : span[SIZE_W-1:0];
        end else begin
          fn = FUNC_FREE;
          sz = SIZE_W'($urandom_range(0, 24'hFFFFFF));
        end
        offer_item(fn, st, sz, 1'b0, '0);
        // Keep offering back to back while the receiver holds off.
        if (!(ph == 1 && k < 12)) maybe_pause();
      end
    end

    wait_replies_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bba_pkg.sv
rtl/bba_div.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
sim/tb_top.sv
